// ===== hdl/tsi_pkg.sv =====
// Package for the time series interpolator: field widths, request and status codes.
// No dependencies.
package tsi_pkg;
  localparam int TableDepth = 256;
  localparam int TimeW = 32;
  localparam int ValW = 16;
  localparam int InBytesW = 80;
  localparam int OutBytesW = 80;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_ORDER = 2'd3;

  typedef struct packed {
    logic [TimeW-1:0] tm;
    logic [ValW-1:0] steer;
    logic [ValW-1:0] thr;
    logic [ValW-1:0] brk;
  } entry_t;
endpackage

// ===== hdl/time_series_interpolator.sv =====
// Time series interpolator top level: breakpoint table in one synchronous memory.
// Depends on tsi_pkg.
// Query path: binary search of the table (probe and wait state per search probe),
// a serial divide for the 16-bit fraction, then a signed multiply per channel.
// One request at a time.
// Reset clears the entry count and control state; table contents stay undefined.
module time_series_interpolator #(
  parameter int TABLE_DEPTH = tsi_pkg::TableDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // time_value[31:0], steering[47:32], throttle[63:48], braking[79:64]
  input  logic [tsi_pkg::InBytesW-1:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // out_time[31:0], out_steering[47:32], out_throttle[63:48], out_braking[79:64]
  output logic [tsi_pkg::OutBytesW-1:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0] m_axis_tuser
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_FIRST = 4'd1, S_LASTRD = 4'd2,
    S_CHECK = 4'd3, S_PROBE = 4'd4, S_PWAIT = 4'd5, S_RDR = 4'd6,
    S_RDL = 4'd7, S_DIV = 4'd8, S_MUL = 4'd9, S_OUT = 4'd10, S_APPW = 4'd11,
    S_LERP = 4'd12;

  tsi_pkg::entry_t mem [TABLE_DEPTH];
  tsi_pkg::entry_t rd;
  logic [AW-1:0] raddr;
  logic we;
  logic [AW-1:0] waddr;
  tsi_pkg::entry_t wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  logic [3:0] state;
  logic [CW-1:0] count;
  logic [31:0] q;
  tsi_pkg::entry_t inent, e0, er, el;
  logic [CW-1:0] lo, hi;
  logic [4:0] dcnt;
  logic [32:0] rem;
  logic [31:0] span;
  logic [15:0] frac;
  logic [1:0] ch;
  logic signed [34:0] prod;
  logic [47:0] res;
  logic [1:0] status;
  logic [CW-1:0] mid;

  assign mid = lo + ((hi - lo) >> 1);
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign m_axis_tdata = {res, q};
  assign m_axis_tuser = status;

  logic signed [16:0] dv;
  logic signed [15:0] va, vb;
  always_comb begin
    unique case (ch)
      2'd0: begin va = el.steer; vb = er.steer; end
      2'd1: begin va = el.thr; vb = er.thr; end
      default: begin va = el.brk; vb = er.brk; end
    endcase
    dv = 17'(vb) - 17'(va);
  end

  always_comb begin
    raddr = '0;
    priority case (state)
      S_IDLE: raddr = '0;
      S_FIRST, S_LASTRD: raddr = AW'(count - 1'b1);
      S_PROBE: raddr = mid[AW-1:0];
      S_RDR, S_RDL: raddr = AW'(lo - 1'b1);
      default: raddr = lo[AW-1:0];
    endcase
    if (state == S_IDLE && s_axis_tuser == tsi_pkg::REQ_APPEND)
      raddr = AW'(count - 1'b1);
  end

  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          q <= s_axis_tdata[31:0];
          inent <= {s_axis_tdata[31:0], s_axis_tdata[47:32],
                    s_axis_tdata[63:48], s_axis_tdata[79:64]};
          status <= tsi_pkg::ST_OK;
          res <= '0;
          if (s_axis_tuser == tsi_pkg::REQ_APPEND) state <= S_APPW;
          else if (s_axis_tuser == tsi_pkg::REQ_QUERY) begin
            if (count == '0) begin
              status <= tsi_pkg::ST_EMPTY; q <= '0; state <= S_OUT;
            end else state <= S_FIRST;
          end else begin
            if (s_axis_tuser == tsi_pkg::REQ_CLEAR) count <= '0;
            q <= '0; state <= S_OUT;
          end
        end
        S_APPW: begin
          q <= '0;
          if (count == CW'(TABLE_DEPTH)) status <= tsi_pkg::ST_FULL;
          else if (count != '0 && inent.tm <= rd.tm) status <= tsi_pkg::ST_ORDER;
          else begin
            we <= 1'b1; waddr <= count[AW-1:0]; wdata <= inent;
            count <= count + 1'b1;
          end
          state <= S_OUT;
        end
        S_FIRST: begin e0 <= rd; state <= S_LASTRD; end
        S_LASTRD: state <= S_CHECK;
        S_CHECK: begin
          if (q <= e0.tm) begin
            q <= e0.tm; res <= {e0.brk, e0.thr, e0.steer}; state <= S_OUT;
          end else if (q >= rd.tm) begin
            q <= rd.tm; res <= {rd.brk, rd.thr, rd.steer}; state <= S_OUT;
          end else begin
            lo <= '0; hi <= count; state <= S_PROBE;
          end
        end
        S_PROBE: state <= (lo < hi) ? S_PWAIT : S_RDR;
        S_PWAIT: begin
          if (rd.tm < q) lo <= mid + 1'b1; else hi <= mid;
          state <= S_PROBE;
        end
        S_RDR: begin
          er <= rd;
          if (rd.tm == q) begin
            res <= {rd.brk, rd.thr, rd.steer}; state <= S_OUT;
          end else state <= S_RDL;
        end
        S_RDL: state <= S_LERP;
        S_LERP: begin
          el <= rd;
          span <= er.tm - rd.tm;
          rem <= {1'b0, q - rd.tm};
          dcnt <= '0; frac <= '0; state <= S_DIV;
        end
        S_DIV: begin
          if (dcnt == 5'd16) begin ch <= 2'd0; dcnt <= '0; state <= S_MUL; end
          else begin
            logic [32:0] r2;
            r2 = {rem[31:0], 1'b0};
            if (r2 >= {1'b0, span}) begin
              rem <= r2 - {1'b0, span}; frac <= {frac[14:0], 1'b1};
            end else begin
              rem <= r2; frac <= {frac[14:0], 1'b0};
            end
            dcnt <= dcnt + 1'b1;
          end
        end
        S_MUL: begin
          if (dcnt[0] == 1'b0) begin
            prod <= $signed({1'b0, frac}) * dv; dcnt <= 5'd1;
          end else begin
            logic [15:0] v;
            v = 16'(va + 16'(prod >>> 16));
            res <= {v, res[47:16]};
            dcnt <= '0;
            if (ch == 2'd2) state <= S_OUT; else ch <= ch + 1'b1;
          end
        end
        S_OUT: begin m_axis_tvalid <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_tx: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("accepting while result pending");
  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH)) else $error("count overflow");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == tsi_pkg::REQ_CLEAR)
    |=> count == '0) else $error("clear missed");
endmodule
